### hdl/hmt_pkg.sv
package hmt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [31:0] SELF_ID_RST   = 32'd1;
  localparam logic [15:0] SELF_PORT_RST = 16'd0;

  typedef enum logic [1:0] {
    CMD_MERGE   = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_DUMP    = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_UPDATED  = 3'd0,
    ST_STALE    = 3'd1,
    ST_APPENDED = 3'd2,
    ST_FULL     = 3'd3,
    ST_LISTED   = 3'd4,
    ST_DONE     = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    OSEL_HIT,
    OSEL_MISS,
    OSEL_TICK,
    OSEL_RESTART,
    OSEL_LIST
  } osel_t;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] port;
    logic [31:0] hb;
    logic [31:0] ts;
  } entry_t;

  typedef struct packed {
    status_t status;
    entry_t  ent;
    logic    last;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic             cap_in;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] hit_idx;
    logic             load_out;
    osel_t            osel;
    logic             out_last;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             match;
    logic             out_free;
  } sts_t;

endpackage

### hdl/hmt_ctrl.sv
module hmt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  hmt_pkg::cmd_t      in_cmd,
  input  hmt_pkg::sts_t      sts,
  output hmt_pkg::ctl_t      ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_EMIT,
    S_DRD,
    S_DOUT
  } state_t;

  state_t                     state_r, state_nxt;
  logic [hmt_pkg::CNT_W-1:0]  idx_r, idx_nxt;
  logic                       pend_r, pend_nxt;
  hmt_pkg::osel_t             osel_r, osel_nxt;
  logic [hmt_pkg::IDX_W-1:0]  hit_idx_r, hit_idx_nxt;
  logic                       dump_last;

  assign in_tready = (state_r == S_IDLE);
  assign dump_last = (idx_r == sts.count);

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    pend_nxt     = pend_r;
    osel_nxt     = osel_r;
    hit_idx_nxt  = hit_idx_r;
    ctl          = '0;
    ctl.rd_addr  = idx_r[hmt_pkg::IDX_W-1:0];
    ctl.hit_idx  = hit_idx_r;
    ctl.osel     = osel_r;
    ctl.out_last = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          ctl.cap_in = 1'b1;
          idx_nxt    = '0;
          pend_nxt   = 1'b0;
          unique case (in_cmd)
            hmt_pkg::CMD_MERGE: state_nxt = S_SRCH;
            hmt_pkg::CMD_TICK: begin
              osel_nxt  = hmt_pkg::OSEL_TICK;
              state_nxt = S_EMIT;
            end
            hmt_pkg::CMD_DUMP: state_nxt = S_DRD;
            default: begin
              osel_nxt  = hmt_pkg::OSEL_RESTART;
              state_nxt = S_EMIT;
            end
          endcase
        end
      end
      S_SRCH: begin
        // read entry idx while comparing the entry held in the read register
        if (pend_r && sts.match) begin
          osel_nxt    = hmt_pkg::OSEL_HIT;
          hit_idx_nxt = hmt_pkg::IDX_W'(idx_r - hmt_pkg::CNT_W'(1));
          state_nxt   = S_EMIT;
        end else if (idx_r == sts.count) begin
          osel_nxt  = hmt_pkg::OSEL_MISS;
          state_nxt = S_EMIT;
        end else begin
          ctl.rd_en = 1'b1;
          idx_nxt   = idx_r + hmt_pkg::CNT_W'(1);
          pend_nxt  = 1'b1;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          ctl.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_DRD: begin
        ctl.rd_en = 1'b1;
        idx_nxt   = idx_r + hmt_pkg::CNT_W'(1);
        state_nxt = S_DOUT;
      end
      S_DOUT: begin
        ctl.osel     = hmt_pkg::OSEL_LIST;
        ctl.out_last = dump_last;
        if (sts.out_free) begin
          ctl.load_out = 1'b1;
          state_nxt    = dump_last ? S_IDLE : S_DRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      idx_r     <= '0;
      pend_r    <= 1'b0;
      osel_r    <= hmt_pkg::OSEL_TICK;
      hit_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      pend_r    <= pend_nxt;
      osel_r    <= osel_nxt;
      hit_idx_r <= hit_idx_nxt;
    end
  end

endmodule

### hdl/hmt_dpath.sv
module hmt_dpath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [31:0]           in_id,
  input  logic [15:0]           in_port,
  input  logic [31:0]           in_hb,
  input  logic [31:0]           self_id,
  input  logic [15:0]           self_port,
  input  hmt_pkg::ctl_t         ctl,
  output hmt_pkg::sts_t         sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hmt_pkg::out_t         out_word
);

  hmt_pkg::entry_t             mem_r [hmt_pkg::TABLE_DEPTH];
  hmt_pkg::entry_t             e0_r, e0_nxt;
  hmt_pkg::entry_t             rd_r;
  hmt_pkg::entry_t             in_r;
  hmt_pkg::entry_t             wr_data;
  logic                        wr_en;
  logic [hmt_pkg::IDX_W-1:0]   wr_addr;
  logic [hmt_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [31:0]                 lhb_r, lhb_nxt, lhb_inc;
  logic                        out_valid_r, out_valid_nxt;
  hmt_pkg::out_t               out_r, out_nxt;
  logic                        newer, full;

  assign lhb_inc = (lhb_r == '1) ? lhb_r : lhb_r + 32'd1;
  assign newer   = (in_r.hb > rd_r.hb);
  assign full    = (count_r == hmt_pkg::CNT_W'(hmt_pkg::TABLE_DEPTH));

  assign sts.count    = count_r;
  assign sts.match    = (rd_r.id == in_r.id) && (rd_r.port == in_r.port);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  always_comb begin
    e0_nxt        = e0_r;
    count_nxt     = count_r;
    lhb_nxt       = lhb_r;
    wr_en         = 1'b0;
    wr_addr       = ctl.hit_idx;
    wr_data       = rd_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (ctl.load_out) begin
      out_valid_nxt = 1'b1;
      out_nxt.last  = 1'b1;
      case (ctl.osel)
        hmt_pkg::OSEL_HIT: begin
          out_nxt.ent = rd_r;
          if (newer) begin
            out_nxt.status = hmt_pkg::ST_UPDATED;
            out_nxt.ent.hb = in_r.hb;
            out_nxt.ent.ts = lhb_r;
            wr_data        = out_nxt.ent;
            if (ctl.hit_idx == '0) begin
              e0_nxt = out_nxt.ent;
            end else begin
              wr_en = 1'b1;
            end
          end else begin
            out_nxt.status = hmt_pkg::ST_STALE;
          end
        end
        hmt_pkg::OSEL_MISS: begin
          out_nxt.ent    = in_r;
          out_nxt.ent.ts = lhb_r;
          if (full) begin
            out_nxt.status = hmt_pkg::ST_FULL;
          end else begin
            out_nxt.status = hmt_pkg::ST_APPENDED;
            wr_en          = 1'b1;
            wr_addr        = count_r[hmt_pkg::IDX_W-1:0];
            wr_data        = out_nxt.ent;
            count_nxt      = count_r + hmt_pkg::CNT_W'(1);
          end
        end
        hmt_pkg::OSEL_TICK: begin
          lhb_nxt        = lhb_inc;
          e0_nxt.hb      = lhb_inc;
          e0_nxt.ts      = lhb_inc;
          out_nxt.status = hmt_pkg::ST_DONE;
          out_nxt.ent    = e0_nxt;
        end
        hmt_pkg::OSEL_RESTART: begin
          e0_nxt.id      = self_id;
          e0_nxt.port    = self_port;
          e0_nxt.hb      = lhb_r;
          e0_nxt.ts      = lhb_r;
          count_nxt      = hmt_pkg::CNT_W'(1);
          out_nxt.status = hmt_pkg::ST_DONE;
          out_nxt.ent    = e0_nxt;
        end
        default: begin
          out_nxt.status = hmt_pkg::ST_LISTED;
          out_nxt.ent    = rd_r;
          out_nxt.last   = ctl.out_last;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e0_r        <= '{id: hmt_pkg::SELF_ID_RST, port: hmt_pkg::SELF_PORT_RST,
                       hb: 32'd0, ts: 32'd0};
      count_r     <= hmt_pkg::CNT_W'(1);
      lhb_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      e0_r        <= e0_nxt;
      count_r     <= count_nxt;
      lhb_r       <= lhb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (ctl.cap_in) begin
      in_r <= '{id: in_id, port: in_port, hb: in_hb, ts: 32'd0};
    end
  end

  // table memory, entry zero lives in e0_r
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_r <= (ctl.rd_addr == '0) ? e0_r : mem_r[ctl.rd_addr];
    end
  end

endmodule

### hdl/heartbeat_membership_table_unit.sv
// Gossip heartbeat membership table of up to 16 entries, entry zero being
// the node itself, plus a saturating local heartbeat. Merge (tuser 0) looks
// the member up by id and port one stored entry per cycle through the
// registered table read; tick (1) and restart (3) send a single word each;
// dump (2) sends one word per entry, tlast on the final one. A stalled
// receiver holds up each result until the output register is free. One
// item is worked on at a time; a finished word waits in the output register
// while the next item is taken. self_id and self_port are copied into entry
// zero only on restart; after reset entry zero holds their reset values.
module heartbeat_membership_table_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [79:0]  in_tdata,   // member_id, member_port, member_heartbeat
  input  logic [1:0]   in_tuser,   // command
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,  // entry_id, entry_port, entry_heartbeat,
                                   // entry_timestamp
  output logic [2:0]   out_tuser,  // status
  output logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [31:0]   self_id_r, self_id_nxt;
  logic [15:0]   self_port_r, self_port_nxt;
  logic          cfg_wr;
  hmt_pkg::ctl_t ctl;
  hmt_pkg::sts_t sts;
  hmt_pkg::out_t out_word;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = cfg_paddr[2] ? {16'd0, self_port_r} : self_id_r;

  always_comb begin
    self_id_nxt   = self_id_r;
    self_port_nxt = self_port_r;
    if (cfg_wr) begin
      if (cfg_paddr[2]) begin
        self_port_nxt = cfg_pwdata[15:0];
      end else begin
        self_id_nxt = cfg_pwdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      self_id_r   <= hmt_pkg::SELF_ID_RST;
      self_port_r <= hmt_pkg::SELF_PORT_RST;
    end else begin
      self_id_r   <= self_id_nxt;
      self_port_r <= self_port_nxt;
    end
  end

  hmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (hmt_pkg::cmd_t'(in_tuser)),
    .sts       (sts),
    .ctl       (ctl)
  );

  hmt_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_id     (in_tdata[31:0]),
    .in_port   (in_tdata[47:32]),
    .in_hb     (in_tdata[79:48]),
    .self_id   (self_id_r),
    .self_port (self_port_r),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_word  (out_word)
  );

  assign out_tdata = {out_word.ent.ts, out_word.ent.hb, out_word.ent.port, out_word.ent.id};
  assign out_tuser = out_word.status;
  assign out_tlast = out_word.last;

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while previous one still in work");

  a_last_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != hmt_pkg::ST_LISTED) |-> out_tlast)
    else $error("single-word result without tlast");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (sts.count != '0) && (sts.count <= hmt_pkg::CNT_W'(hmt_pkg::TABLE_DEPTH)))
    else $error("entry count out of range");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load_out |-> sts.out_free)
    else $error("output register overwritten");
`endif

endmodule

### dv/membership_table_checker.sv
`timescale 1ns / 1ps

module membership_table_checker
  import hmt_pkg::*;
#(
  parameter logic [2:0] SELF_ID_ADDR   = 3'd0,
  parameter logic [2:0] SELF_PORT_ADDR = 3'd4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [79:0]  in_tdata,   // member_id, member_port, member_heartbeat
  input  logic [1:0]   in_tuser,   // command
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [111:0] out_tdata,  // entry_id, entry_port, entry_heartbeat,
                                   // entry_timestamp
  input  logic [2:0]   out_tuser,  // status
  input  logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  input  logic         cfg_pready,
  output int           mismatches,
  output int           pending_words
);

  logic [31:0] self_id_q;
  logic [15:0] self_port_q;
  entry_t      members [TABLE_DEPTH];
  int          used;
  logic [31:0] beat;
  out_t        due_words [$];

  initial begin
    mismatches    = 0;
    pending_words = 0;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic void queue_word(status_t st, entry_t ent, logic lst);
    out_t w;
    w.status  = st;
    w.ent     = ent;
    w.last    = lst;
    due_words = {due_words, w};
  endfunction

  function automatic void rebuild_members();
    for (int i = 0; i < TABLE_DEPTH; i++)
      members[i] = '0;
    members[0].id   = self_id_q;
    members[0].port = self_port_q;
    members[0].hb   = beat;
    members[0].ts   = beat;
    used = 1;
  endfunction

  function automatic void predict_command(cmd_t cmd, logic [31:0] id, logic [15:0] port,
                                          logic [31:0] hb);
    int     hit;
    entry_t ent;
    hit = -1;
    case (cmd)
      CMD_MERGE: begin
        for (int i = 0; i < used; i++)
          if (hit < 0 && members[i].id == id && members[i].port == port)
            hit = i;
        if (hit >= 0) begin
          if (hb > members[hit].hb) begin
            members[hit].hb = hb;
            members[hit].ts = beat;
            queue_word(ST_UPDATED, members[hit], 1'b1);
          end else begin
            queue_word(ST_STALE, members[hit], 1'b1);
          end
        end else begin
          ent.id   = id;
          ent.port = port;
          ent.hb   = hb;
          ent.ts   = beat;
          if (used >= TABLE_DEPTH) begin
            queue_word(ST_FULL, ent, 1'b1);
          end else begin
            members[used] = ent;
            used++;
            queue_word(ST_APPENDED, ent, 1'b1);
          end
        end
      end
      CMD_TICK: begin
        // local heartbeat saturates
        if (beat != 32'hFFFF_FFFF)
          beat = beat + 32'd1;
        members[0].hb = beat;
        members[0].ts = beat;
        queue_word(ST_DONE, members[0], 1'b1);
      end
      CMD_DUMP: begin
        for (int i = 0; i < used; i++)
          queue_word(ST_LISTED, members[i], i == used - 1);
      end
      default: begin
        rebuild_members();
        queue_word(ST_DONE, members[0], 1'b1);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    out_t got;
    out_t want;
    if (!rst_n) begin
      self_id_q   = SELF_ID_RST;
      self_port_q = SELF_PORT_RST;
      beat        = '0;
      rebuild_members();
      due_words.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.status  = status_t'(out_tuser);
        got.ent.id   = out_tdata[31:0];
        got.ent.port = out_tdata[47:32];
        got.ent.hb   = out_tdata[79:48];
        got.ent.ts   = out_tdata[111:80];
        got.last     = out_tlast;
        if (due_words.size() == 0) begin
          report_mismatch("unexpected word id", got.ent.id, '0);
        end else begin
          want = due_words.pop_front();
          if (got.status != want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
          if (got.ent.id != want.ent.id)
            report_mismatch("entry_id", got.ent.id, want.ent.id);
          if (got.ent.port != want.ent.port)
            report_mismatch("entry_port", 32'(got.ent.port), 32'(want.ent.port));
          if (got.ent.hb != want.ent.hb)
            report_mismatch("entry_heartbeat", got.ent.hb, want.ent.hb);
          if (got.ent.ts != want.ent.ts)
            report_mismatch("entry_timestamp", got.ent.ts, want.ent.ts);
          if (got.last != want.last)
            report_mismatch("last", 32'(got.last), 32'(want.last));
        end
      end
      if (in_tvalid && in_tready)
        predict_command(cmd_t'(in_tuser), in_tdata[31:0], in_tdata[47:32], in_tdata[79:48]);
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr == SELF_ID_ADDR)
          self_id_q = cfg_pwdata;
        else if (cfg_paddr == SELF_PORT_ADDR)
          self_port_q = cfg_pwdata[15:0];
      end
    end
    pending_words <= due_words.size();
  end

endmodule

### dv/heartbeat_membership_table_unit_test.sv
`timescale 1ns / 1ps

module heartbeat_membership_table_unit_test;
  import hmt_pkg::*;

  localparam logic [2:0] REG_SELF_ID   = 3'd0;
  localparam logic [2:0] REG_SELF_PORT = 3'd4;
  localparam int         HOLD_CYCLES   = 200;
  localparam int         PHASE_WORDS   = 89;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [79:0]  in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [111:0] out_tdata;
  logic [2:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [2:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  int mismatches;
  int pending_words;
  int send_idle;
  int stall_pct;
  bit hold_req;

  // members seen so far, reused so that merges hit stored entries
  logic [31:0] known_ids [$];
  logic [15:0] known_ports [$];

  heartbeat_membership_table_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  membership_table_checker #(
    .SELF_ID_ADDR   (REG_SELF_ID),
    .SELF_PORT_ADDR (REG_SELF_PORT)
  ) checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_pready    (cfg_pready),
    .mismatches    (mismatches),
    .pending_words (pending_words)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // receiver side, with a long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic send_word(cmd_t cmd, logic [31:0] id, logic [15:0] port, logic [31:0] hb);
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {hb, port, id};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_self(logic [31:0] id, logic [15:0] port);
    cfg_write(REG_SELF_ID, id);
    cfg_write(REG_SELF_PORT, {16'($urandom), port});
    known_ids   = {known_ids, id};
    known_ports = {known_ports, port};
  endtask

  task automatic run_phase(int idle, int stall, bit with_hold, bit with_pause);
    int          r;
    int          j;
    logic [31:0] id;
    logic [15:0] port;
    logic [31:0] hb;
    send_idle = idle;
    stall_pct = stall;
    send_word(CMD_RESTART, $urandom, 16'($urandom), $urandom);
    for (int k = 1; k < PHASE_WORDS; k++) begin
      if (with_hold && k == 10)
        hold_req = 1'b1;
      if (with_pause && k == PHASE_WORDS / 2)
        drain();
      r    = $urandom_range(0, 99);
      id   = $urandom;
      port = 16'($urandom);
      hb   = $urandom;
      if (r < 65) begin
        if (known_ids.size() > 0 && $urandom_range(0, 99) < 55) begin
          j  = $urandom_range(0, known_ids.size() - 1);
          id = known_ids[j];
          if ($urandom_range(0, 9) != 0)
            port = known_ports[j];
          if ($urandom_range(0, 3) != 0)
            hb = $urandom_range(0, 60);
        end else begin
          if ($urandom_range(0, 3) == 0)
            hb = $urandom_range(0, 60);
          known_ids   = {known_ids, id};
          known_ports = {known_ports, port};
          if (known_ids.size() > 24) begin
            void'(known_ids.pop_front());
            void'(known_ports.pop_front());
          end
        end
        send_word(CMD_MERGE, id, port, hb);
      end else if (r < 85) begin
        send_word(CMD_TICK, id, port, hb);
      end else if (r < 97) begin
        send_word(CMD_DUMP, id, port, hb);
      end else begin
        send_word(CMD_RESTART, id, port, hb);
      end
    end
    drain();
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    send_idle   = 0;
    stall_pct   = 0;
    hold_req    = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers take effect only on restart, so the first dump shows reset values
    set_self(32'hFFFF_FFFF, 16'hFFFF);
    send_word(CMD_DUMP, '0, '0, '0);
    send_word(CMD_TICK, '0, '0, '0);
    send_word(CMD_MERGE, SELF_ID_RST, SELF_PORT_RST, 32'd0);
    send_word(CMD_MERGE, SELF_ID_RST, SELF_PORT_RST, 32'd1);
    send_word(CMD_MERGE, SELF_ID_RST, SELF_PORT_RST, 32'hFFFF_FFFF);
    send_word(CMD_MERGE, 32'd0, 16'd0, 32'd0);
    send_word(CMD_MERGE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    for (int k = 0; k < TABLE_DEPTH - 3; k++)
      send_word(CMD_MERGE, $urandom, 16'($urandom), $urandom);
    send_word(CMD_MERGE, 32'h0000_5A5A, 16'hA5A5, 32'd7);
    send_word(CMD_MERGE, 32'd0, 16'd0, 32'd5);
    send_word(CMD_DUMP, '0, '0, '0);
    send_word(CMD_RESTART, '0, '0, '0);
    send_word(CMD_DUMP, '0, '0, '0);
    drain();

    set_self(32'd0, 16'd0);
    run_phase(0, 0, 1'b1, 1'b0);
    set_self($urandom, 16'($urandom));
    run_phase(77, 0, 1'b0, 1'b1);
    set_self(32'hFFFF_FFFF, 16'hFFFF);
    run_phase(0, 77, 1'b0, 1'b0);
    set_self($urandom, 16'($urandom));
    run_phase(32, 32, 1'b0, 1'b0);

    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
